FILE: hw/rtl/nnpo_pkg.sv
// ----------------------------------------------------------------------------
// nnpo_pkg
// shared constants and types of the nearest-neighbor part order block
// ----------------------------------------------------------------------------
`default_nettype none

package nnpo_pkg;

    // default sizes
    localparam int DEF_MAX_PARTS  = 64;
    localparam int DEF_COORD_BITS = 24;

    // fixed field widths on the stream ports
    localparam int POS_W     = 24;
    localparam int IDX_W     = 6;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    // tuser codes of the input stream
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_CENTER = 1'b1;

    // control tag that travels with a scan read through the distance pipe
    typedef struct packed {
        logic vld;   // a scan read is in flight
        logic cand;  // entry not yet picked
        logic last;  // last entry of this scan
    } t_tag;

endpackage

`default_nettype wire

FILE: hw/rtl/nearest_neighbor_part_order_core.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_part_order_core
// greedy nearest-neighbor visiting order over loaded part centers
// ----------------------------------------------------------------------------
// input stream: tuser 0 sets the start point, tuser 1 appends a part center;
// tlast on a center closes the list and starts the ordering. centers past
// MAX_PARTS are dropped, but their tlast still starts the ordering.
// loads are taken one per cycle. while ordering, s_axis_tready is low.
// for N stored centers the block runs N steps; each step reads all N entries
// of the center memory, one per cycle, through the registered read and the
// distance pipe (abs difference, squares, sum), then picks the nearest
// unpicked entry and writes its picked flag back when the output is free.
// output stream: one transaction per center, the index in load order,
// tlast on the final one. the output register holds a result while
// m_axis_tready is low and the ordering waits for it.
// after a run the center count is cleared; the current point stays on the
// last picked center. reset clears count and current point (origin).
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_part_order_core #(
    parameter int MAX_PARTS  = nnpo_pkg::DEF_MAX_PARTS,
    parameter int COORD_BITS = nnpo_pkg::DEF_COORD_BITS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire [nnpo_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // pos_x, pos_y
    input  wire                             s_axis_tlast,  // final_center
    input  wire [0:0]                       s_axis_tuser,  // mode
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [nnpo_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // part_index, zero pad
    output logic                            m_axis_tlast   // last_of_run
);

    localparam int AW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int CB = COORD_BITS;
    localparam int DW = 2 * CB + 1;
    localparam int PW = nnpo_pkg::POS_W;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_PICK
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count, r_total, r_issue, r_step;
    logic signed [CB-1:0]       r_cur_x, r_cur_y;
    logic                       r_have;
    logic [AW-1:0]              r_best_idx;
    logic [2*CB:0]              r_best_d;
    logic signed [CB-1:0]       r_best_x, r_best_y;
    logic                       r_m_valid, r_m_last;
    logic [nnpo_pkg::IDX_W-1:0] r_m_idx;

    logic signed [CB-1:0] w_in_x, w_in_y;
    logic                 w_acc, w_center, w_room, w_fire, w_upd;
    logic [CW-1:0]        n_count;
    logic                 w_we, w_re;
    logic [AW-1:0]        w_waddr;
    logic [DW-1:0]        w_wdata, w_rdata;
    logic [AW-1:0]        w_ridx;
    logic                 w_rvld, w_rlast;
    nnpo_pkg::t_tag       w_tag_in, w_dtag;
    logic [AW-1:0]        w_didx;
    logic signed [CB-1:0] w_dx, w_dy;
    logic [2*CB:0]        w_dist;

    // input coordinates: low COORD_BITS bits, or sign extension of the field
    generate
        if (CB <= PW) begin : g_narrow
            assign w_in_x = s_axis_tdata[CB-1:0];
            assign w_in_y = s_axis_tdata[PW+CB-1:PW];
        end else begin : g_wide
            assign w_in_x = {{(CB-PW){s_axis_tdata[PW-1]}}, s_axis_tdata[PW-1:0]};
            assign w_in_y = {{(CB-PW){s_axis_tdata[2*PW-1]}}, s_axis_tdata[2*PW-1:PW]};
        end
    endgenerate

    assign s_axis_tready = (r_state == S_LOAD);
    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_center   = (s_axis_tuser[0] == nnpo_pkg::MODE_CENTER);
    assign w_room     = (r_count < CW'(MAX_PARTS));
    assign n_count    = r_count + CW'(w_room);
    assign w_fire     = (r_state == S_PICK) && (!r_m_valid || m_axis_tready);

    // memory writes: center load, or picked flag write-back after a scan
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = {1'b0, w_in_y, w_in_x};
        if (w_fire) begin
            w_we    = 1'b1;
            w_waddr = r_best_idx;
            w_wdata = {1'b1, r_best_y, r_best_x};
        end else if (w_acc && w_center && w_room) begin
            w_we = 1'b1;
        end
    end

    assign w_re = (r_state == S_SCAN);

    nnpo_store #(
        .DEPTH (MAX_PARTS),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_issue[AW-1:0]),
        .i_rlast (r_issue == r_total - CW'(1)),
        .o_rdata (w_rdata),
        .o_ridx  (w_ridx),
        .o_rvld  (w_rvld),
        .o_rlast (w_rlast)
    );

    // tag fields from the top: vld, cand, last
    assign w_tag_in = {w_rvld, w_rvld && !w_rdata[DW-1], w_rvld && w_rlast};

    nnpo_dist #(
        .CB (CB),
        .AW (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag_in),
        .i_idx   (w_ridx),
        .i_x     (w_rdata[CB-1:0]),
        .i_y     (w_rdata[2*CB-1:CB]),
        .i_cur_x (r_cur_x),
        .i_cur_y (r_cur_y),
        .o_tag   (w_dtag),
        .o_idx   (w_didx),
        .o_x     (w_dx),
        .o_y     (w_dy),
        .o_dist  (w_dist)
    );

    // strict compare in index order keeps the lower index on a tie
    assign w_upd = w_dtag.vld && w_dtag.cand && (!r_have || (w_dist < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_total   <= '0;
            r_issue   <= '0;
            r_step    <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_have    <= 1'b0;
            r_m_valid <= 1'b0;
            r_m_idx   <= '0;
            r_m_last  <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_upd) begin
                r_have <= 1'b1;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (!w_center) begin
                            r_cur_x <= w_in_x;
                            r_cur_y <= w_in_y;
                        end else begin
                            r_count <= n_count;
                            if (s_axis_tlast) begin
                                r_total <= n_count;
                                r_issue <= '0;
                                r_step  <= '0;
                                r_have  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_issue <= r_issue + CW'(1);
                    if (r_issue == r_total - CW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_dtag.vld && w_dtag.last) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (w_fire) begin
                        r_m_valid <= 1'b1;
                        r_m_idx   <= (nnpo_pkg::IDX_W)'(r_best_idx);
                        r_m_last  <= (r_step == r_total - CW'(1));
                        r_cur_x   <= r_best_x;
                        r_cur_y   <= r_best_y;
                        r_have    <= 1'b0;
                        r_issue   <= '0;
                        r_step    <= r_step + CW'(1);
                        if (r_step == r_total - CW'(1)) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_best_idx <= w_didx;
            r_best_d   <= w_dist;
            r_best_x   <= w_dx;
            r_best_y   <= w_dy;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = (nnpo_pkg::M_TDATA_W)'(r_m_idx);
    assign m_axis_tlast  = r_m_last;

    // a pick always has a candidate from the finished scan
    a_pick_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> r_have)
        else $error("pick without a candidate");

    // the store never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PARTS))
        else $error("center count beyond depth");

    // write-back of a picked flag only once the scan pipe is empty
    a_wb_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> (!w_rvld && !w_dtag.vld))
        else $error("write-back overlaps a scan read");

    // steps never run past the number of stored centers
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_step < r_total))
        else $error("step count beyond stored centers");

    // no distance result arrives while loading
    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !w_dtag.vld)
        else $error("distance result while loading");

endmodule

`default_nettype wire

FILE: hw/rtl/nnpo_store.sv
// ----------------------------------------------------------------------------
// nnpo_store
// center memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module nnpo_store #(
    parameter int DEPTH = nnpo_pkg::DEF_MAX_PARTS,
    parameter int AW    = $clog2(nnpo_pkg::DEF_MAX_PARTS),
    parameter int DW    = 2 * nnpo_pkg::DEF_COORD_BITS + 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  wire [DW-1:0]        i_wdata,
    input  wire                 i_re,
    input  wire [AW-1:0]        i_raddr,
    input  wire logic           i_rlast,
    output logic [DW-1:0]       o_rdata,
    output logic [AW-1:0]       o_ridx,
    output logic                o_rvld,
    output logic                o_rlast
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
            o_ridx  <= i_raddr;
            o_rlast <= i_rlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rvld <= 1'b0;
        end else begin
            o_rvld <= i_re;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/nnpo_dist.sv
// ----------------------------------------------------------------------------
// nnpo_dist
// three-stage squared distance pipe: abs difference, squares, sum
// ----------------------------------------------------------------------------
`default_nettype none

module nnpo_dist #(
    parameter int CB = nnpo_pkg::DEF_COORD_BITS,
    parameter int AW = $clog2(nnpo_pkg::DEF_MAX_PARTS)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire nnpo_pkg::t_tag     i_tag,
    input  wire [AW-1:0]            i_idx,
    input  wire signed [CB-1:0]     i_x,
    input  wire signed [CB-1:0]     i_y,
    input  wire signed [CB-1:0]     i_cur_x,
    input  wire signed [CB-1:0]     i_cur_y,
    output nnpo_pkg::t_tag          o_tag,
    output logic [AW-1:0]           o_idx,
    output logic signed [CB-1:0]    o_x,
    output logic signed [CB-1:0]    o_y,
    output logic [2*CB:0]           o_dist
);

    nnpo_pkg::t_tag       r_tag1, r_tag2;
    logic [AW-1:0]        r_idx1, r_idx2;
    logic signed [CB-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [CB-1:0]        r_adx, r_ady;
    logic [2*CB-1:0]      r_sqx, r_sqy;
    logic signed [CB:0]   w_dx, w_dy;

    assign w_dx = {i_x[CB-1], i_x} - {i_cur_x[CB-1], i_cur_x};
    assign w_dy = {i_y[CB-1], i_y} - {i_cur_y[CB-1], i_cur_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            o_tag  <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            o_tag  <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        // magnitude of a difference of two CB-bit values fits in CB bits
        r_adx  <= w_dx[CB] ? CB'(-w_dx) : w_dx[CB-1:0];
        r_ady  <= w_dy[CB] ? CB'(-w_dy) : w_dy[CB-1:0];
        r_idx1 <= i_idx;
        r_x1   <= i_x;
        r_y1   <= i_y;

        r_sqx  <= r_adx * r_adx;
        r_sqy  <= r_ady * r_ady;
        r_idx2 <= r_idx1;
        r_x2   <= r_x1;
        r_y2   <= r_y1;

        o_dist <= {1'b0, r_sqx} + {1'b0, r_sqy};
        o_idx  <= r_idx2;
        o_x    <= r_x2;
        o_y    <= r_y2;
    end

endmodule

`default_nettype wire

FILE: tb/sv/nearest_neighbor_part_order_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_neighbor_part_order_core_tb
// self-checking bench for the greedy nearest-neighbor part order block
// ----------------------------------------------------------------------------
// a short table of start points and centers (extremes, ties, duplicates,
// runs with no start point) is followed by random runs of centers, two of
// them filling and overflowing the center store. every output transaction is
// compared with the visiting order the bench works out itself from accepted
// inputs, or with the result that a single-center row of the table gives.
// both sides idle at random: one steady stretch, one long hold-off, two full drains.
// ----------------------------------------------------------------------------

module nearest_neighbor_part_order_core_tb;

    localparam int   MAX_PARTS   = nnpo_pkg::DEF_MAX_PARTS;
    localparam int   POS_W       = nnpo_pkg::POS_W;
    localparam int   IDX_W       = nnpo_pkg::IDX_W;
    localparam int   S_TDATA_W   = nnpo_pkg::S_TDATA_W;
    localparam int   M_TDATA_W   = nnpo_pkg::M_TDATA_W;
    localparam logic MODE_START  = nnpo_pkg::MODE_START;
    localparam logic MODE_CENTER = nnpo_pkg::MODE_CENTER;
    localparam int   POS_MAX     = (1 << (POS_W - 1)) - 1;
    localparam int   POS_MIN     = -(1 << (POS_W - 1));
    localparam int   RAND_ITEMS  = 212;
    localparam int   HOLD_CYCLES = 400;
    localparam int   DRAIN_WAIT  = 200;
    localparam int   IDLE_PCT    = 27;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_order;

    typedef struct {
        bit mode;
        int x;
        int y;
        bit fin;
        bit typed;   // expected result given in the row (single-center run)
        int t_idx;
        bit t_last;
    } t_stim_row;

    typedef enum int {COORD_WIDE, COORD_CLUSTER, COORD_EXTREME} t_coord_style;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata   = '0;  // pos_x, pos_y
    logic                  s_axis_tlast   = 1'b0; // final_center
    logic [0:0]            s_axis_tuser   = '0;  // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;         // part_index, zero pad
    logic                  m_axis_tlast;         // last_of_run

    // own copy of the block state
    logic signed [POS_W-1:0] ctr_x [MAX_PARTS];
    logic signed [POS_W-1:0] ctr_y [MAX_PARTS];
    bit                      picked [MAX_PARTS];
    int unsigned             ctr_count = 0;
    logic signed [POS_W-1:0] cur_x = '0;
    logic signed [POS_W-1:0] cur_y = '0;

    t_order pending_order[$];
    int     mismatches = 0;
    bit     steady     = 1'b0;
    int     hold_asks  = 0;
    int     hold_taken = 0;
    int     hold_left  = 0;

    t_stim_row directed_rows[18] = '{
        // no start point after reset: walk from the origin
        '{MODE_CENTER, 0, 0, 1'b1, 1'b1, 0, 1'b1},
        // start point, final flag must be ignored
        '{MODE_START, POS_MAX, POS_MAX, 1'b1, 1'b0, 0, 1'b0},
        '{MODE_CENTER, POS_MIN, POS_MIN, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, POS_MAX, POS_MIN, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, POS_MIN, POS_MAX, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, POS_MAX, POS_MAX, 1'b1, 1'b0, 0, 1'b0},
        // four centers at equal distance: lower index wins
        '{MODE_START, 0, 0, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, 5, 0, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, -5, 0, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, 0, 5, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, 0, -5, 1'b1, 1'b0, 0, 1'b0},
        // duplicate centers
        '{MODE_CENTER, 3, 3, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, 3, 3, 1'b1, 1'b0, 0, 1'b0},
        '{MODE_CENTER, POS_MIN, POS_MAX, 1'b1, 1'b1, 0, 1'b1},
        // no new start point: walk from the end of the last run
        '{MODE_CENTER, 1, 1, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, 2, 2, 1'b1, 1'b0, 0, 1'b0},
        '{MODE_START, -1, -1, 1'b0, 1'b0, 0, 1'b0},
        '{MODE_CENTER, POS_MIN, POS_MIN, 1'b1, 1'b1, 0, 1'b1}
    };

    nearest_neighbor_part_order_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint unsigned sq_dist(input logic signed [POS_W-1:0] ax,
                                                input logic signed [POS_W-1:0] ay,
                                                input logic signed [POS_W-1:0] bx,
                                                input logic signed [POS_W-1:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return longint'(dx * dx + dy * dy);
    endfunction

    // updates the state for one accepted transaction, returns the order it causes
    function automatic void plan_order(input bit mode,
                                       input logic signed [POS_W-1:0] px,
                                       input logic signed [POS_W-1:0] py,
                                       input bit fin,
                                       output t_order steps[$]);
        int unsigned     total;
        int unsigned     best;
        longint unsigned best_d;
        longint unsigned d;
        bit              have;
        t_order          one;
        steps = {};
        if (mode == MODE_START) begin
            cur_x = px;
            cur_y = py;
            return;
        end
        if (ctr_count < MAX_PARTS) begin
            ctr_x[ctr_count] = px;
            ctr_y[ctr_count] = py;
            ctr_count++;
        end
        if (!fin) return;
        total = ctr_count;
        for (int unsigned s = 0; s < total; s++) begin
            have   = 1'b0;
            best   = 0;
            best_d = 0;
            for (int unsigned n = 0; n < total; n++) begin
                if (picked[n]) continue;
                d = sq_dist(ctr_x[n], ctr_y[n], cur_x, cur_y);
                if (!have || d < best_d) begin
                    have   = 1'b1;
                    best   = n;
                    best_d = d;
                end
            end
            picked[best] = 1'b1;
            cur_x        = ctr_x[best];
            cur_y        = ctr_y[best];
            one.idx      = best[IDX_W-1:0];
            one.last     = (s + 1 == total);
            steps        = {steps, one};
        end
        foreach (picked[i]) picked[i] = 1'b0;
        ctr_count = 0;
    endfunction

    function automatic int pick_coord(input t_coord_style style);
        case (style)
            COORD_WIDE: begin
                return int'($urandom);
            end
            COORD_CLUSTER: begin
                return int'($urandom_range(0, 16)) - 8;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return POS_MAX;
                    1: return POS_MIN;
                    2: return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    task automatic send_item(input bit mode, input int x, input int y, input bit fin,
                             input bit typed = 1'b0, input int t_idx = 0,
                             input bit t_last = 1'b0);
        t_order steps[$];
        t_order typed_step;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= fin;
        s_axis_tdata  <= {y[POS_W-1:0], x[POS_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        plan_order(mode, x[POS_W-1:0], y[POS_W-1:0], fin, steps);
        if (typed) begin
            typed_step.idx  = t_idx[IDX_W-1:0];
            typed_step.last = t_last;
            pending_order   = {pending_order, typed_step};
        end else begin
            foreach (steps[i]) pending_order = {pending_order, steps[i]};
        end
    endtask

    // sender pause: nothing offered until the whole order has come out
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (pending_order.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input t_order want,
                                 input logic [M_TDATA_W-1:0] got_data, input logic got_last);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected index %0d last %0b, got tdata 0x%02h last %0b",
                     what, want.idx, want.last, got_data, got_last);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_taken != hold_asks) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_order want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_order.size() == 0) begin
                want.idx  = '0;
                want.last = 1'b0;
                flag_mismatch("unexpected transaction", want, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_order.pop_front();
                if (m_axis_tdata !== {{(M_TDATA_W - IDX_W){1'b0}}, want.idx}
                        || m_axis_tlast !== want.last)
                    flag_mismatch("order mismatch", want, m_axis_tdata, m_axis_tlast);
            end
        end
    end

    initial begin
        int           rand_items;
        int           run_no;
        int           n_ctr;
        t_coord_style style;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].mode, directed_rows[r].x, directed_rows[r].y,
                      directed_rows[r].fin, directed_rows[r].typed,
                      directed_rows[r].t_idx, directed_rows[r].t_last);
        drain_results();

        rand_items = 0;
        run_no     = 0;
        while (rand_items < RAND_ITEMS) begin
            // run 2 fills the store exactly, run 5 overflows it
            if (run_no == 2)
                n_ctr = MAX_PARTS;
            else if (run_no == 5)
                n_ctr = MAX_PARTS + 6;
            else if (run_no == 7)
                n_ctr = 8;
            else
                n_ctr = $urandom_range(1, 10);
            style  = t_coord_style'($urandom_range(0, 2));
            steady = (run_no == 3 || run_no == 4);
            if ($urandom_range(0, 99) < 80) begin
                send_item(MODE_START, pick_coord(style), pick_coord(style),
                          bit'($urandom_range(0, 1)));
                rand_items++;
            end
            for (int k = 0; k < n_ctr; k++) begin
                // now and then a start point lands inside a list
                if (k != 0 && $urandom_range(0, 99) < 10) begin
                    send_item(MODE_START, pick_coord(style), pick_coord(style),
                              bit'($urandom_range(0, 1)));
                    rand_items++;
                end
                // long hold-off while this order streams out and the next run waits
                if (run_no == 7 && k == n_ctr - 1) hold_asks++;
                send_item(MODE_CENTER, pick_coord(style), pick_coord(style), k == n_ctr - 1);
                rand_items++;
            end
            run_no++;
        end
        steady = 1'b0;
        drain_results();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
